### rtl/bed_pkg.sv
`default_nettype none

package bed_pkg;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_THREE     = 8'h33;
    localparam logic [7:0] CH_SEVEN     = 8'h37;

    localparam logic [1:0] PH_NORMAL = 2'd0;
    localparam logic [1:0] PH_ESC    = 2'd1;
    localparam logic [1:0] PH_OCT1   = 2'd2;
    localparam logic [1:0] PH_OCT2   = 2'd3;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic       run_last;
        logic       token_end;
        logic       bad_escape;
        logic       has_byte;
        logic [7:0] out_byte;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } dec_out_t;

    // {hit, mapped byte} for single-letter escapes
    function automatic logic [8:0] control_map(input logic [7:0] c);
        logic [8:0] m;
        case (c)
            8'h61:        m = {1'b1, 8'h07};
            8'h62:        m = {1'b1, 8'h08};
            8'h66:        m = {1'b1, 8'h0C};
            8'h6E:        m = {1'b1, 8'h0A};
            8'h72:        m = {1'b1, 8'h0D};
            8'h73:        m = {1'b1, 8'h20};
            8'h74:        m = {1'b1, 8'h09};
            8'h76:        m = {1'b1, 8'h0B};
            CH_BACKSLASH: m = {1'b1, CH_BACKSLASH};
            default:      m = 9'd0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

### rtl/bed_in_stage.sv
`default_nettype none

module bed_in_stage
    import bed_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    input  wire logic  [7:0] s_tdata,   // in_byte
    input  wire logic  s_tlast,         // token_last
    input  wire logic  advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.data <= s_tdata;
            item_reg.last <= s_tlast;
        end
    end

endmodule

`default_nettype wire

### rtl/bed_decode.sv
`default_nettype none

module bed_decode
    import bed_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    input  wire item_t item,
    input  wire logic  out_free,
    output logic       advance,
    output dec_out_t   dec
);

    logic [1:0] phase_reg, phase_next;
    logic [4:0] part_reg, part_next;
    logic       err_reg, err_next;

    logic [7:0] c;
    logic       is_oct03;
    logic       is_oct07;
    logic [8:0] cmap;
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] ph_s;
    logic       err_s;
    logic       err_fin;
    logic [7:0] oct_val;

    assign c        = item.data;
    assign is_oct03 = (c >= CH_ZERO) && (c <= CH_THREE);
    assign is_oct07 = (c >= CH_ZERO) && (c <= CH_SEVEN);
    assign cmap     = control_map(c);
    assign oct_val  = {part_reg, c[2:0]};

    always_comb
    begin
        n          = 2'd0;
        b0         = 8'd0;
        b1         = 8'd0;
        ph_s       = phase_reg;
        part_next  = part_reg;
        err_s      = err_reg;
        if (!err_reg)
        begin
            case (phase_reg)
                PH_NORMAL:
                begin
                    if (c == CH_BACKSLASH)
                    begin
                        ph_s = PH_ESC;
                    end
                    else
                    begin
                        n  = 2'd1;
                        b0 = c;
                    end
                end
                PH_ESC:
                begin
                    if (is_oct03)
                    begin
                        part_next = {3'd0, c[1:0]};
                        ph_s      = PH_OCT1;
                    end
                    else if (cmap[8])
                    begin
                        n    = 2'd1;
                        b0   = cmap[7:0];
                        ph_s = PH_NORMAL;
                    end
                    else
                    begin
                        n    = 2'd2;
                        b0   = CH_BACKSLASH;
                        b1   = c;
                        ph_s = PH_NORMAL;
                    end
                end
                PH_OCT1:
                begin
                    if (is_oct07)
                    begin
                        part_next = {part_reg[1:0], c[2:0]};
                        ph_s      = PH_OCT2;
                    end
                    else
                    begin
                        err_s = 1'b1;
                    end
                end
                default:
                begin
                    if (is_oct07)
                    begin
                        n         = 2'd1;
                        b0        = oct_val;
                        ph_s      = PH_NORMAL;
                        part_next = 5'd0;
                    end
                    else
                    begin
                        err_s = 1'b1;
                    end
                end
            endcase
        end

        err_fin    = err_s || (ph_s != PH_NORMAL);
        phase_next = ph_s;
        err_next   = err_s;

        dec.count  = n;
        dec.r0     = '{run_last: (n == 2'd1), token_end: 1'b0, bad_escape: 1'b0,
                       has_byte: 1'b1, out_byte: b0};
        dec.r1     = '{run_last: 1'b1, token_end: 1'b0, bad_escape: 1'b0,
                       has_byte: 1'b1, out_byte: b1};

        if (item.last)
        begin
            if (err_fin || (n == 2'd0))
            begin
                dec.count = 2'd1;
                dec.r0    = '{run_last: 1'b1, token_end: 1'b1, bad_escape: err_fin,
                              has_byte: 1'b0, out_byte: 8'd0};
            end
            else if (n == 2'd1)
            begin
                dec.r0.token_end = 1'b1;
            end
            else
            begin
                dec.r1.token_end = 1'b1;
            end
            phase_next = PH_NORMAL;
            part_next  = 5'd0;
            err_next   = 1'b0;
        end
    end

    assign advance = item_valid && ((dec.count == 2'd0) || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NORMAL;
            part_reg  <= 5'd0;
            err_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            part_reg  <= part_next;
            err_reg   <= err_next;
        end
    end

endmodule

`default_nettype wire

### rtl/bed_out_buf.sv
`default_nettype none

module bed_out_buf
    import bed_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load,
    input  wire dec_out_t dec,
    output logic          out_free,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    output result_t       head
);

    logic [1:0] cnt_reg, cnt_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic       pop;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign out_free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);
    assign head     = slot0_reg;

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load)
        begin
            cnt_next   = dec.count;
            slot0_next = dec.r0;
            slot1_next = dec.r1;
        end
        else if (pop)
        begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

### rtl/backslash_escape_decoder_top.sv
`default_nettype none

// Backslash escape decoder for name tokens. Raw bytes enter on the s_ side, one per
// transfer, with s_tlast on the final byte of a token; decoded bytes leave on the m_ side.
// An item passes an input register, the decode logic and a two-slot result register, so
// one byte is taken per cycle while m_tready is high; an unknown escape yields two results
// and holds the next byte while the second result drains. Every token closes with one
// result that has m_tlast set and carries the error flag; after an error the token's
// remaining bytes yield nothing until that end result.
module backslash_escape_decoder_top
    import bed_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // token_last
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [2:0]      m_tuser,   // [0] has_byte, [1] bad_escape, [2] run_last
    output logic            m_tlast    // token_end
);

    logic      item_valid;
    item_t     item;
    logic      advance;
    logic      out_free;
    dec_out_t  dec;
    result_t   head;

    bed_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bed_decode u_dec (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .advance    (advance),
        .dec        (dec)
    );

    bed_out_buf u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && (dec.count != 2'd0)),
        .dec      (dec),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    assign m_tdata = head.out_byte;
    assign m_tuser = {head.run_last, head.bad_escape, head.has_byte};
    assign m_tlast = head.token_end;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (dec.count != 2'd0)) |-> out_free)
        else $error("result load into a busy buffer");

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> m_tuser[2])
        else $error("token end without run_last");

    a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("empty result that is not a token end");

    a_bad_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (!m_tuser[0] && m_tlast && (m_tdata == 8'd0)))
        else $error("error flag on a data result");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`default_nettype none

module tb_top;
    import bed_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    localparam logic [7:0] CTRL_LETTERS [9] = '{"a", "b", "f", "n", "r", "s", "t", "v",
                                                CH_BACKSLASH};

    item_t      pending_bytes[$];
    result_t    expected_results[$];
    logic [7:0] token_bytes[$];

    logic [1:0] esc_phase = PH_NORMAL;
    logic [4:0] oct_acc = 5'd0;
    logic       tok_err = 1'b0;

    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int rx_stall_cycles = 0;

    backslash_escape_decoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [8:0] letter_code(input logic [7:0] c);
        case (c)
            "a":          return {1'b1, 8'h07};
            "b":          return {1'b1, 8'h08};
            "f":          return {1'b1, 8'h0C};
            "n":          return {1'b1, 8'h0A};
            "r":          return {1'b1, 8'h0D};
            "s":          return {1'b1, 8'h20};
            "t":          return {1'b1, 8'h09};
            "v":          return {1'b1, 8'h0B};
            CH_BACKSLASH: return {1'b1, CH_BACKSLASH};
            default:      return 9'h000;
        endcase
    endfunction

    function automatic result_t byte_result(input logic [7:0] b, input logic has);
        result_t r;
        r = '0;
        r.out_byte = has ? b : 8'h00;
        r.has_byte = has;
        return r;
    endfunction

    task automatic decode_byte(input logic [7:0] c, input logic last);
        result_t    outs[$];
        result_t    r;
        logic [8:0] lm;
        lm = letter_code(c);
        if (!tok_err)
        begin
            case (esc_phase)
                PH_NORMAL:
                begin
                    if (c == CH_BACKSLASH)
                        esc_phase = PH_ESC;
                    else
                        outs.push_back(byte_result(c, 1'b1));
                end
                PH_ESC:
                begin
                    if (c >= CH_ZERO && c <= CH_THREE)
                    begin
                        oct_acc = {3'b000, c[1:0]};
                        esc_phase = PH_OCT1;
                    end
                    else if (lm[8])
                    begin
                        outs.push_back(byte_result(lm[7:0], 1'b1));
                        esc_phase = PH_NORMAL;
                    end
                    else
                    begin
                        outs.push_back(byte_result(CH_BACKSLASH, 1'b1));
                        outs.push_back(byte_result(c, 1'b1));
                        esc_phase = PH_NORMAL;
                    end
                end
                PH_OCT1:
                begin
                    if (c >= CH_ZERO && c <= CH_SEVEN)
                    begin
                        oct_acc = {oct_acc[1:0], c[2:0]};
                        esc_phase = PH_OCT2;
                    end
                    else
                        tok_err = 1'b1;
                end
                default:
                begin
                    if (c >= CH_ZERO && c <= CH_SEVEN)
                    begin
                        outs.push_back(byte_result({oct_acc, c[2:0]}, 1'b1));
                        esc_phase = PH_NORMAL;
                        oct_acc = 5'd0;
                    end
                    else
                        tok_err = 1'b1;
                end
            endcase
        end
        if (last)
        begin
            if (esc_phase != PH_NORMAL)
                tok_err = 1'b1;
            if (tok_err)
                outs.delete();
            if (outs.size() == 0)
                outs.push_back(byte_result(8'h00, 1'b0));
            r = outs.pop_back();
            r.bad_escape = tok_err;
            r.token_end = 1'b1;
            outs.push_back(r);
            esc_phase = PH_NORMAL;
            oct_acc = 5'd0;
            tok_err = 1'b0;
        end
        if (outs.size() > 0)
        begin
            r = outs.pop_back();
            r.run_last = 1'b1;
            outs.push_back(r);
        end
        foreach (outs[i])
            expected_results.push_back(outs[i]);
    endtask

    task automatic field_check(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result();
        result_t want;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result: tdata %0h tuser %0h tlast %0b", m_tdata, m_tuser, m_tlast);
            mismatch_count++;
        end
        else
        begin
            want = expected_results.pop_front();
            field_check("out_byte", want.out_byte, m_tdata);
            field_check("has_byte", 8'(want.has_byte), 8'(m_tuser[0]));
            field_check("bad_escape", 8'(want.bad_escape), 8'(m_tuser[1]));
            field_check("run_last", 8'(want.run_last), 8'(m_tuser[2]));
            field_check("token_end", 8'(want.token_end), 8'(m_tlast));
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_bytes[0].data;
                    s_tlast  <= pending_bytes[0].last;
                    void'(pending_bytes.pop_front());
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (rx_stall_cycles != 0)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (rx_stall_cycles > 0)
            rx_stall_cycles <= rx_stall_cycles - 1;
    end

    function automatic logic [7:0] non_octal();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b >= CH_ZERO && b <= CH_SEVEN)
            b ^= 8'h40;
        return b;
    endfunction

    task automatic queue_token();
        item_t it;
        foreach (token_bytes[i])
        begin
            it.data = token_bytes[i];
            it.last = (i == token_bytes.size() - 1);
            pending_bytes.push_back(it);
        end
        token_bytes.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            token_bytes.push_back(s[i]);
        queue_token();
    endtask

    task automatic add_piece();
        int         kind;
        logic [7:0] b;
        logic [8:0] lm;
        kind = $urandom_range(99);
        if (kind < 40)
        begin
            b = 8'($urandom_range(255));
            if (b == CH_BACKSLASH)
                b = 8'h5D;
            token_bytes.push_back(b);
        end
        else if (kind < 55)
        begin
            token_bytes.push_back(CH_BACKSLASH);
            token_bytes.push_back(CTRL_LETTERS[$urandom_range(8)]);
        end
        else if (kind < 75)
        begin
            token_bytes.push_back(CH_BACKSLASH);
            token_bytes.push_back(CH_ZERO + 8'($urandom_range(3)));
            token_bytes.push_back(CH_ZERO + 8'($urandom_range(7)));
            token_bytes.push_back(CH_ZERO + 8'($urandom_range(7)));
        end
        else if (kind < 85)
        begin
            b = 8'($urandom_range(255));
            lm = letter_code(b);
            if ((b >= CH_ZERO && b <= CH_THREE) || lm[8])
                b = "x";
            token_bytes.push_back(CH_BACKSLASH);
            token_bytes.push_back(b);
        end
        else if (kind < 93)
        begin
            token_bytes.push_back(CH_BACKSLASH);
            token_bytes.push_back(CH_ZERO + 8'($urandom_range(3)));
            if ($urandom_range(1) == 1)
                token_bytes.push_back(CH_ZERO + 8'($urandom_range(7)));
            token_bytes.push_back(non_octal());
        end
        else
            token_bytes.push_back(CH_BACKSLASH);
    endtask

    task automatic queue_random(input int count);
        int added;
        int keep;
        added = 0;
        while (added < count)
        begin
            repeat ($urandom_range(1, 6))
                add_piece();
            // cut the token short now and then so it can end mid-escape
            if ($urandom_range(9) == 0)
            begin
                keep = $urandom_range(1, token_bytes.size());
                while (token_bytes.size() > keep)
                    void'(token_bytes.pop_back());
            end
            added += token_bytes.size();
            queue_token();
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || s_tvalid)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        send_idle_pct = 24;
        recv_idle_pct = 81;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        token_bytes.push_back(8'h00);
        token_bytes.push_back(8'hFF);
        queue_token();
        send_text("\\n");
        send_text("\\377\\x");
        send_text("\\000\\\\");
        send_text("\\25zA");
        send_text("\\19");
        send_text("\\");
        queue_random(525);
        wait_drained();

        send_idle_pct = 81;
        recv_idle_pct = 24;
        queue_random(550);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        rx_stall_cycles = 300;
        queue_random(550);
        wait_drained();

        repeat (20) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
